/* design/amlp_pkg.sv */
// shared types and constants for the light controller
`default_nettype none
package amlp_pkg;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_MODE = 2'd1,
    KIND_LED  = 2'd2,
    KIND_NOP  = 2'd3
  } kind_t;

  // where the duty of an item comes from
  typedef enum logic [1:0] {
    DUTY_KEEP = 2'd0,
    DUTY_ZERO = 2'd1,
    DUTY_FULL = 2'd2,
    DUTY_PID  = 2'd3
  } duty_src_t;

  localparam logic [2:0] REG_GAIN_P    = 3'd0;
  localparam logic [2:0] REG_GAIN_I    = 3'd1;
  localparam logic [2:0] REG_GAIN_D    = 3'd2;
  localparam logic [2:0] REG_THRESHOLD = 3'd3;
  localparam logic [2:0] REG_DEBOUNCE  = 3'd4;
  localparam logic [2:0] REG_ALARM_MIN = 3'd5;

  localparam logic [7:0] FULL_DUTY   = 8'd255;
  localparam int         QUEUE_DEPTH = 4;

  // classified item as it sits in the queue
  typedef struct packed {
    kind_t              kind;
    logic [31:0]        now_ms;
    logic               mode_button;
    logic               led_button;
    logic               high;
    logic               alarm_hit;
    logic               remote_value;
    logic signed [8:0]  err;
  } item_t;

  // settings the back part needs
  typedef struct packed {
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [15:0] debounce_ms;
  } back_cfg_t;

endpackage
`default_nettype wire

/* design/auto_manual_light_pid.sv */
// Light controller with manual override and a Q8.8 PID loop on the feedback
// sample. One item is accepted per clock when the result side keeps up; a
// result passes through the queue, the state update stage, the multiply stage
// and the output register with sum and clamp. The state update stage, which
// holds the mode, debounce times and error sum, takes one item per cycle
// while the output is not stalled and sets the rate. A four-entry queue lets
// the input side keep accepting while a result waits. Configuration writes
// are taken at any time and must only be made while no item is in flight.
`default_nettype none
module auto_manual_light_pid import amlp_pkg::*; #(
  parameter int SUM_BITS    = 21,
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // now_ms[31:0], mode_button[32], led_button[33], ambient_sample[45:34],
  // feedback_sample[57:46], minute_of_day[68:58], remote_value[69], zeros[71:70]
  input  wire logic [71:0] s_tdata,
  // kind[1:0]
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // led_duty[7:0], buzzer_on[8], manual_active[9], manual_led_on[10],
  // alarm_has_fired[11], sum_saturated[12], zeros[15:13]
  output logic [15:0]      m_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [15:0] gain_p;
  logic [15:0] gain_i;
  logic [15:0] gain_d;
  logic [11:0] ambient_threshold;
  logic [15:0] debounce_ms;
  logic [10:0] alarm_minute;

  item_t     front_item;
  item_t     q_head;
  logic      q_full;
  logic      q_empty;
  logic      q_pop;
  logic      push;
  back_cfg_t back_cfg;

  logic [7:0] led_duty;
  logic       buzzer_on;
  logic       manual_active;
  logic       manual_led_on;
  logic       alarm_has_fired;
  logic       sum_saturated;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p            <= 16'd128;
      gain_i            <= 16'd13;
      gain_d            <= 16'd26;
      ambient_threshold <= 12'd4000;
      debounce_ms       <= 16'd300;
      alarm_minute      <= 11'd618;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GAIN_P:    gain_p            <= cfg_data;
        REG_GAIN_I:    gain_i            <= cfg_data;
        REG_GAIN_D:    gain_d            <= cfg_data;
        REG_THRESHOLD: ambient_threshold <= cfg_data[11:0];
        REG_DEBOUNCE:  debounce_ms       <= cfg_data;
        REG_ALARM_MIN: alarm_minute      <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  assign back_cfg.gain_p      = gain_p;
  assign back_cfg.gain_i      = gain_i;
  assign back_cfg.gain_d      = gain_d;
  assign back_cfg.debounce_ms = debounce_ms;

  assign s_tready = !q_full;
  assign push     = s_tvalid && s_tready;

  amlp_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .kind              (kind_t'(s_tuser)),
    .now_ms            (s_tdata[31:0]),
    .mode_button       (s_tdata[32]),
    .led_button        (s_tdata[33]),
    .ambient_sample    (s_tdata[45:34]),
    .feedback_sample   (s_tdata[57:46]),
    .minute_of_day     (s_tdata[68:58]),
    .remote_value      (s_tdata[69]),
    .ambient_threshold (ambient_threshold),
    .alarm_minute      (alarm_minute),
    .item              (front_item)
  );

  amlp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  amlp_back #(
    .SUM_BITS(SUM_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (back_cfg),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .led_duty        (led_duty),
    .buzzer_on       (buzzer_on),
    .manual_active   (manual_active),
    .manual_led_on   (manual_led_on),
    .alarm_has_fired (alarm_has_fired),
    .sum_saturated   (sum_saturated)
  );

  assign m_tdata = {3'd0, sum_saturated, alarm_has_fired, manual_led_on,
                    manual_active, buzzer_on, led_duty};

endmodule
`default_nettype wire

/* design/amlp_front.sv */
// front part: scales feedback, compares ambient and alarm minute, builds the queue item
`default_nettype none
module amlp_front import amlp_pkg::*; #(
  parameter int SAMPLE_BITS = 12
) (
  input  wire kind_t       kind,
  input  wire logic [31:0] now_ms,
  input  wire logic        mode_button,
  input  wire logic        led_button,
  input  wire logic [11:0] ambient_sample,
  input  wire logic [11:0] feedback_sample,
  input  wire logic [10:0] minute_of_day,
  input  wire logic        remote_value,
  input  wire logic [11:0] ambient_threshold,
  input  wire logic [10:0] alarm_minute,
  output item_t            item
);

  localparam logic [SAMPLE_BITS:0] SAMPLE_MAX = (SAMPLE_BITS + 1)'((1 << SAMPLE_BITS) - 1);

  logic [15:0]              fb_ext;
  logic [SAMPLE_BITS-1:0]   fb;
  logic [SAMPLE_BITS+7:0]   scaled;
  logic [7:0]               q0;
  logic [SAMPLE_BITS:0]     rem;
  logic [7:0]               meas;
  logic                     high;

  assign fb_ext = {4'd0, feedback_sample};
  assign fb     = fb_ext[SAMPLE_BITS-1:0];
  assign scaled = (SAMPLE_BITS + 8)'(fb) * (SAMPLE_BITS + 8)'(FULL_DUTY);

  // divide by 2^n - 1: quotient estimate from the top bits, one correction step
  assign q0   = scaled[SAMPLE_BITS+7:SAMPLE_BITS];
  assign rem  = {1'b0, scaled[SAMPLE_BITS-1:0]} + (SAMPLE_BITS + 1)'(q0);
  assign meas = q0 + ((rem >= SAMPLE_MAX) ? 8'd1 : 8'd0);

  assign high = ambient_sample >= ambient_threshold;

  always_comb begin
    item.kind         = kind;
    item.now_ms       = now_ms;
    item.mode_button  = mode_button;
    item.led_button   = led_button;
    item.high         = high;
    item.alarm_hit    = minute_of_day == alarm_minute;
    item.remote_value = remote_value;
    item.err          = (high ? $signed({1'b0, FULL_DUTY}) : 9'sd0) - $signed({1'b0, meas});
  end

endmodule
`default_nettype wire

/* design/amlp_queue.sv */
// short queue of classified items between front and back
`default_nettype none
module amlp_queue import amlp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       full,
  input  wire logic  pop,
  output logic       empty,
  output item_t      head
);

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  item_t               entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign full  = count == CNT_BITS'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

/* design/amlp_back.sv */
// back part: state update, pid products, sum and clamp, output register
`default_nettype none
module amlp_back import amlp_pkg::*; #(
  parameter int SUM_BITS = 21
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire back_cfg_t cfg,
  input  wire logic      q_empty,
  input  wire item_t     q_head,
  output logic           q_pop,
  output logic           out_valid,
  input  wire logic      out_ready,
  output logic [7:0]     led_duty,
  output logic           buzzer_on,
  output logic           manual_active,
  output logic           manual_led_on,
  output logic           alarm_has_fired,
  output logic           sum_saturated
);

  localparam int AW = SUM_BITS + 19;
  localparam logic signed [AW-1:0] ACC_MAX = AW'(65280);

  logic en;

  // persistent control state
  logic                       manual_mode;
  logic                       manual_led;
  logic [31:0]                last_mode_press;
  logic [31:0]                last_led_press;
  logic signed [SUM_BITS-1:0] error_sum;
  logic signed [8:0]          previous_error;
  logic                       buzzer_reg;
  logic                       alarm_done;

  logic                       manual_mode_next;
  logic                       manual_led_next;
  logic [31:0]                last_mode_press_next;
  logic [31:0]                last_led_press_next;
  logic signed [SUM_BITS-1:0] error_sum_next;
  logic signed [8:0]          previous_error_next;
  logic                       buzzer_reg_next;
  logic                       alarm_done_next;
  duty_src_t                  src_next;
  logic                       sat_next;
  logic signed [9:0]          deriv_next;
  logic signed [SUM_BITS:0]   sum_wide;

  // stage 1 payload
  logic                       s1_valid;
  duty_src_t                  s1_src;
  logic signed [8:0]          s1_err;
  logic signed [9:0]          s1_deriv;
  logic signed [SUM_BITS-1:0] s1_sum;
  logic                       s1_buzzer;
  logic                       s1_mode;
  logic                       s1_led;
  logic                       s1_alarm;
  logic                       s1_sat;

  // stage 2 payload
  logic                       s2_valid;
  duty_src_t                  s2_src;
  logic signed [25:0]         p_prod;
  logic signed [SUM_BITS+16:0] i_prod;
  logic signed [26:0]         d_prod;
  logic                       s2_buzzer;
  logic                       s2_mode;
  logic                       s2_led;
  logic                       s2_alarm;
  logic                       s2_sat;

  logic signed [AW-1:0]       acc;
  logic [7:0]                 pid_duty;
  logic [7:0]                 duty_next;

  assign en    = !out_valid || out_ready;
  assign q_pop = en && !q_empty;

  assign sum_wide = $signed({error_sum[SUM_BITS-1], error_sum})
                  + $signed({{(SUM_BITS - 8){q_head.err[8]}}, q_head.err});

  always_comb begin
    manual_mode_next     = manual_mode;
    manual_led_next      = manual_led;
    last_mode_press_next = last_mode_press;
    last_led_press_next  = last_led_press;
    error_sum_next       = error_sum;
    previous_error_next  = previous_error;
    buzzer_reg_next      = buzzer_reg;
    alarm_done_next      = alarm_done;
    src_next             = DUTY_KEEP;
    sat_next             = 1'b0;
    deriv_next           = $signed({q_head.err[8], q_head.err})
                         - $signed({previous_error[8], previous_error});
    unique case (q_head.kind)
      KIND_TICK: begin
        if (q_head.mode_button &&
            (q_head.now_ms - last_mode_press) > {16'd0, cfg.debounce_ms}) begin
          manual_mode_next     = !manual_mode;
          last_mode_press_next = q_head.now_ms;
        end
        if (manual_mode_next && q_head.led_button &&
            (q_head.now_ms - last_led_press) > {16'd0, cfg.debounce_ms}) begin
          manual_led_next     = !manual_led;
          src_next            = manual_led ? DUTY_ZERO : DUTY_FULL;
          last_led_press_next = q_head.now_ms;
        end
        if (!manual_mode_next) begin
          buzzer_reg_next = q_head.high;
          // saturate when the top two bits of the widened sum disagree
          if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
            sat_next       = 1'b1;
            error_sum_next = sum_wide[SUM_BITS] ? {1'b1, {(SUM_BITS - 1){1'b0}}}
                                                : {1'b0, {(SUM_BITS - 1){1'b1}}};
          end else begin
            error_sum_next = sum_wide[SUM_BITS-1:0];
          end
          previous_error_next = q_head.err;
          src_next            = q_head.high ? DUTY_PID : DUTY_ZERO;
        end
        if (!alarm_done && q_head.alarm_hit) begin
          src_next        = DUTY_FULL;
          buzzer_reg_next = 1'b1;
          alarm_done_next = 1'b1;
        end
      end
      KIND_MODE: begin
        manual_mode_next = q_head.remote_value;
      end
      KIND_LED: begin
        if (manual_mode) begin
          manual_led_next = q_head.remote_value;
          src_next        = q_head.remote_value ? DUTY_FULL : DUTY_ZERO;
        end
      end
      KIND_NOP: begin
        src_next = DUTY_KEEP;
      end
      default: begin
        src_next = DUTY_KEEP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      manual_mode     <= 1'b0;
      manual_led      <= 1'b0;
      last_mode_press <= '0;
      last_led_press  <= '0;
      error_sum       <= '0;
      previous_error  <= '0;
      buzzer_reg      <= 1'b0;
      alarm_done      <= 1'b0;
      s1_valid        <= 1'b0;
      s2_valid        <= 1'b0;
      out_valid       <= 1'b0;
      led_duty        <= '0;
    end else begin
      if (q_pop) begin
        manual_mode     <= manual_mode_next;
        manual_led      <= manual_led_next;
        last_mode_press <= last_mode_press_next;
        last_led_press  <= last_led_press_next;
        error_sum       <= error_sum_next;
        previous_error  <= previous_error_next;
        buzzer_reg      <= buzzer_reg_next;
        alarm_done      <= alarm_done_next;
      end
      if (en) begin
        s1_valid  <= q_pop;
        s2_valid  <= s1_valid;
        out_valid <= s2_valid;
        if (s2_valid) begin
          led_duty <= duty_next;
        end
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (en) begin
      s1_src    <= src_next;
      s1_err    <= q_head.err;
      s1_deriv  <= deriv_next;
      s1_sum    <= error_sum_next;
      s1_buzzer <= buzzer_reg_next;
      s1_mode   <= manual_mode_next;
      s1_led    <= manual_led_next;
      s1_alarm  <= alarm_done_next;
      s1_sat    <= sat_next;

      s2_src    <= s1_src;
      p_prod    <= $signed({1'b0, cfg.gain_p}) * s1_err;
      i_prod    <= $signed({1'b0, cfg.gain_i}) * s1_sum;
      d_prod    <= $signed({1'b0, cfg.gain_d}) * s1_deriv;
      s2_buzzer <= s1_buzzer;
      s2_mode   <= s1_mode;
      s2_led    <= s1_led;
      s2_alarm  <= s1_alarm;
      s2_sat    <= s1_sat;

      if (s2_valid) begin
        buzzer_on       <= s2_buzzer;
        manual_active   <= s2_mode;
        manual_led_on   <= s2_led;
        alarm_has_fired <= s2_alarm;
        sum_saturated   <= s2_sat;
      end
    end
  end

  assign acc = AW'(p_prod) + AW'(i_prod) + AW'(d_prod);

  always_comb begin
    if (acc < 0) begin
      pid_duty = 8'd0;
    end else if (acc > ACC_MAX) begin
      pid_duty = FULL_DUTY;
    end else begin
      pid_duty = acc[15:8];
    end
    case (s2_src)
      DUTY_ZERO: duty_next = 8'd0;
      DUTY_FULL: duty_next = FULL_DUTY;
      DUTY_PID:  duty_next = pid_duty;
      default:   duty_next = led_duty;
    endcase
  end

endmodule
`default_nettype wire

/* verif/auto_manual_light_pid_test.sv */
// self-checking testbench for the light controller with pid loop and manual override
`timescale 1ns / 1ps
module auto_manual_light_pid_test;
  import amlp_pkg::*;

  localparam int     SUM_BITS     = 21;
  localparam int     SAMPLE_BITS  = 12;
  localparam int     SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;
  localparam longint SUM_MAX      = (longint'(1) << (SUM_BITS - 1)) - 1;
  localparam longint SUM_MIN      = -SUM_MAX - 1;
  localparam int     DRAIN_CYCLES = 8;
  localparam int     HOLD_CYCLES  = 60;
  localparam int     LIMIT_NS     = 5_000_000;

  typedef struct {
    kind_t       kind;
    logic [31:0] now_ms;
    logic        mode_button;
    logic        led_button;
    logic [11:0] ambient;
    logic [11:0] feedback;
    logic [10:0] minute;
    logic        remote_value;
  } light_item_t;

  typedef struct {
    logic [7:0] led_duty;
    logic       buzzer_on;
    logic       manual_active;
    logic       manual_led_on;
    logic       alarm_has_fired;
    logic       sum_saturated;
  } light_status_t;

  class status_scoreboard;
    int            gain_p, gain_i, gain_d;
    logic [11:0]   threshold;
    logic [15:0]   debounce;
    logic [10:0]   alarm_minute;
    bit            manual_mode, manual_led, buzzer, alarm_done;
    logic [31:0]   last_mode_press, last_led_press;
    longint        error_sum;
    int            prev_error;
    int            duty;
    light_status_t pending_status[$];
    int            checked, failures, clipped;

    function new();
      gain_p = 128;
      gain_i = 13;
      gain_d = 26;
      threshold = 12'd4000;
      debounce = 16'd300;
      alarm_minute = 11'd618;
      last_mode_press = '0;
      last_led_press = '0;
      error_sum = 0;
      prev_error = 0;
      duty = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        REG_GAIN_P:    gain_p = int'(val);
        REG_GAIN_I:    gain_i = int'(val);
        REG_GAIN_D:    gain_d = int'(val);
        REG_THRESHOLD: threshold = val[11:0];
        REG_DEBOUNCE:  debounce = val;
        REG_ALARM_MIN: alarm_minute = val[10:0];
        default: ;
      endcase
    endfunction

    // advance the predicted controller state by one accepted item
    function void note_item(light_item_t it);
      logic [31:0]   since;
      bit            bright, sat;
      int            tgt, meas, err;
      longint        sum, acc;
      light_status_t st;
      sat = 0;
      case (it.kind)
        KIND_TICK: begin
          since = it.now_ms - last_mode_press;
          if (it.mode_button && since > debounce) begin
            manual_mode = !manual_mode;
            last_mode_press = it.now_ms;
          end
          since = it.now_ms - last_led_press;
          if (manual_mode && it.led_button && since > debounce) begin
            manual_led = !manual_led;
            duty = manual_led ? FULL_DUTY : 0;
            last_led_press = it.now_ms;
          end
          if (!manual_mode) begin
            bright = it.ambient >= threshold;
            tgt = bright ? FULL_DUTY : 0;
            meas = int'(it.feedback) * 255 / SAMPLE_MAX;
            err = tgt - meas;
            buzzer = bright;
            sum = error_sum + err;
            if (sum > SUM_MAX) begin
              sum = SUM_MAX;
              sat = 1;
            end
            if (sum < SUM_MIN) begin
              sum = SUM_MIN;
              sat = 1;
            end
            error_sum = sum;
            acc = longint'(gain_p) * err + longint'(gain_i) * sum
                + longint'(gain_d) * (err - prev_error);
            prev_error = err;
            if (acc < 0) acc = 0;
            if (acc > longint'(FULL_DUTY) * 256) acc = longint'(FULL_DUTY) * 256;
            duty = bright ? int'(acc >>> 8) : 0;
          end
          // one-shot alarm wins over the rest of the tick
          if (!alarm_done && it.minute == alarm_minute) begin
            duty = FULL_DUTY;
            buzzer = 1;
            alarm_done = 1;
          end
        end
        KIND_MODE: manual_mode = it.remote_value;
        KIND_LED: begin
          if (manual_mode) begin
            manual_led = it.remote_value;
            duty = it.remote_value ? FULL_DUTY : 0;
          end
        end
        default: ;
      endcase
      st.led_duty = duty[7:0];
      st.buzzer_on = buzzer;
      st.manual_active = manual_mode;
      st.manual_led_on = manual_led;
      st.alarm_has_fired = alarm_done;
      st.sum_saturated = sat;
      pending_status.push_back(st);
    endfunction

    function void compare_field(string name, int exp, int act);
      if (exp != act) begin
        $error("%s: expected %0d, got %0d", name, exp, act);
        failures++;
      end
    endfunction

    function void check_status(logic [15:0] word);
      light_status_t exp;
      if (pending_status.size() == 0) begin
        $error("status transaction with nothing pending: %h", word);
        failures++;
        return;
      end
      exp = pending_status.pop_front();
      checked++;
      if (word[12]) clipped++;
      compare_field("led_duty", int'(exp.led_duty), int'(word[7:0]));
      compare_field("buzzer_on", int'(exp.buzzer_on), int'(word[8]));
      compare_field("manual_active", int'(exp.manual_active), int'(word[9]));
      compare_field("manual_led_on", int'(exp.manual_led_on), int'(word[10]));
      compare_field("alarm_has_fired", int'(exp.alarm_has_fired), int'(word[11]));
      compare_field("sum_saturated", int'(exp.sum_saturated), int'(word[12]));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  status_scoreboard sb = new();

  bit          no_gaps = 0;
  int          hold_request = 0;
  int          stall_left = 0;
  logic [31:0] clock_ms;
  int          n_ticks, n_remote, n_nop, n_settings;

  auto_manual_light_pid DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // result side: random backpressure plus the occasional long hold-off
  always @(negedge clk) begin
    if (hold_request > 0) begin
      stall_left = hold_request;
      hold_request = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= no_gaps || ($urandom_range(99) >= 33);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_status(m_tdata);
  end

  function automatic light_item_t make_item(kind_t k, logic [31:0] now, bit mb, bit lb,
                                            logic [11:0] amb, logic [11:0] fb,
                                            logic [10:0] minute, bit rv);
    light_item_t it;
    it.kind = k;
    it.now_ms = now;
    it.mode_button = mb;
    it.led_button = lb;
    it.ambient = amb;
    it.feedback = fb;
    it.minute = minute;
    it.remote_value = rv;
    return it;
  endfunction

  // mostly ticks on a time base that moves around the debounce window
  function automatic light_item_t random_item();
    light_item_t it;
    int          r, a;
    int unsigned span;
    r = $urandom_range(99);
    if (r < 80) it.kind = KIND_TICK;
    else if (r < 88) it.kind = KIND_MODE;
    else if (r < 96) it.kind = KIND_LED;
    else it.kind = KIND_NOP;
    span = 32'(sb.debounce);
    span = span * 2 + 2;
    if ($urandom_range(99) < 3) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(span, 0);
    it.now_ms = clock_ms;
    it.mode_button = $urandom_range(99) < 10;
    it.led_button = 1'($urandom_range(1));
    case ($urandom_range(3))
      0: it.ambient = $urandom_range(1) ? 12'hFFF : 12'h000;
      1: begin
        a = int'(sb.threshold) + $urandom_range(4) - 2;
        if (a < 0) a = 0;
        if (a > SAMPLE_MAX) a = SAMPLE_MAX;
        it.ambient = 12'(a);
      end
      default: it.ambient = 12'($urandom_range(SAMPLE_MAX));
    endcase
    if ($urandom_range(3) == 0) it.feedback = $urandom_range(1) ? 12'hFFF : 12'h000;
    else it.feedback = 12'($urandom_range(SAMPLE_MAX));
    if ($urandom_range(99) < 5) it.minute = sb.alarm_minute;
    else it.minute = 11'($urandom_range(2047));
    it.remote_value = 1'($urandom_range(1));
    return it;
  endfunction

  task automatic send_item(light_item_t it);
    while (!no_gaps && $urandom_range(99) < 33) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.kind;
    s_tdata  <= {2'b00, it.remote_value, it.minute, it.feedback, it.ambient,
                 it.led_button, it.mode_button, it.now_ms};
    do @(posedge clk); while (!s_tready);
    sb.note_item(it);
    case (it.kind)
      KIND_TICK: n_ticks++;
      KIND_NOP:  n_nop++;
      default:   n_remote++;
    endcase
    @(negedge clk);
  endtask

  task automatic run_random(int count);
    repeat (count) send_item(random_item());
  endtask

  // stop offering and wait until every expected status has come back
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic write_all(logic [15:0] gp, logic [15:0] gi, logic [15:0] gd,
                           logic [15:0] thr, logic [15:0] dbn, logic [15:0] alarm);
    settle();
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_I, gi);
    write_reg(REG_GAIN_D, gd);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_DEBOUNCE, dbn);
    write_reg(REG_ALARM_MIN, alarm);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  initial begin
    #(LIMIT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part under reset settings
    send_item(make_item(KIND_TICK, 32'd0, 0, 0, 12'd0, 12'd0, 11'd0, 0));
    send_item(make_item(KIND_TICK, 32'd5, 0, 0, 12'hFFF, 12'd0, 11'd1, 0));
    send_item(make_item(KIND_TICK, 32'd6, 0, 0, 12'd4000, 12'hFFF, 11'd2, 0));
    send_item(make_item(KIND_TICK, 32'd7, 0, 0, 12'd3999, 12'hFFF, 11'd3, 0));
    send_item(make_item(KIND_TICK, 32'd8, 0, 0, 12'd3999, 12'd2048, 11'd618, 0));
    send_item(make_item(KIND_TICK, 32'd9, 0, 0, 12'd0, 12'd100, 11'd618, 0));
    send_item(make_item(KIND_TICK, 32'd10, 0, 0, 12'hFFF, 12'd1, 11'h7FF, 1));
    // debounce boundary: equal to the window is rejected, one more is taken
    send_item(make_item(KIND_TICK, 32'd300, 1, 0, 12'hFFF, 12'd0, 11'd4, 0));
    send_item(make_item(KIND_TICK, 32'd301, 1, 0, 12'hFFF, 12'd0, 11'd4, 0));
    send_item(make_item(KIND_TICK, 32'd302, 0, 1, 12'hFFF, 12'd0, 11'd4, 0));
    send_item(make_item(KIND_TICK, 32'd400, 0, 1, 12'hFFF, 12'd0, 11'd4, 0));
    send_item(make_item(KIND_TICK, 32'd500, 0, 0, 12'hFFF, 12'hFFF, 11'd5, 0));
    send_item(make_item(KIND_LED, 32'd501, 0, 0, 12'd0, 12'd0, 11'd0, 0));
    send_item(make_item(KIND_LED, 32'd502, 0, 0, 12'd0, 12'd0, 11'd0, 1));
    send_item(make_item(KIND_MODE, 32'd503, 0, 0, 12'd0, 12'd0, 11'd0, 0));
    send_item(make_item(KIND_LED, 32'd504, 0, 0, 12'd0, 12'd0, 11'd0, 0));
    send_item(make_item(KIND_NOP, 32'hFFFF_FFFF, 1, 1, 12'hFFF, 12'hFFF, 11'h7FF, 1));
    send_item(make_item(KIND_MODE, 32'd505, 1, 1, 12'hFFF, 12'hFFF, 11'h7FF, 1));
    // press times across the 32-bit wrap
    send_item(make_item(KIND_TICK, 32'hFFFF_FF00, 0, 1, 12'd0, 12'd0, 11'd6, 0));
    send_item(make_item(KIND_TICK, 32'h0000_0010, 0, 1, 12'd0, 12'd0, 11'd6, 0));
    send_item(make_item(KIND_TICK, 32'h0000_0030, 0, 1, 12'd0, 12'd0, 11'd6, 0));
    send_item(make_item(KIND_TICK, 32'h0000_0040, 1, 0, 12'hFFF, 12'h800, 11'd1439, 0));
    send_item(make_item(KIND_TICK, 32'h0000_0041, 1, 1, 12'd0, 12'hFFF, 11'd1440, 1));

    clock_ms = $urandom;
    write_all(16'd65535, 16'd65535, 16'd65535, 16'd0, 16'd0, 16'd1439);
    run_random(120);
    write_all(16'd0, 16'd0, 16'd0, 16'd4095, 16'd65535, 16'd0);
    run_random(80);

    repeat (3) begin
      write_all(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                16'($urandom_range(65535)), 16'($urandom_range(SAMPLE_MAX)),
                16'($urandom_range(1000)), 16'($urandom_range(1439)));
      run_random(30);
      if (n_settings == 3) begin
        // long result hold-off while items keep coming, then a gap-free stretch
        hold_request = HOLD_CYCLES;
        no_gaps = 1;
        run_random(100);
        no_gaps = 0;
      end
      run_random(30);
    end

    write_all(16'd128, 16'd13, 16'd26, 16'd4000, 16'd300, 16'd618);
    run_random(50);
    settle();
    run_random(50);

    // one-sided runs that wind the error sum up and then back down
    write_all(16'd128, 16'd13, 16'd26, 16'd2048, 16'd300, 16'd618);
    send_item(make_item(KIND_MODE, 32'd0, 0, 0, 12'd0, 12'd0, 11'd0, 0));
    repeat (20) send_item(make_item(KIND_TICK, $urandom, 1'b0, 1'($urandom_range(1)),
                                    12'hFFF, 12'd0, 11'd0, 1'($urandom_range(1))));
    repeat (20) send_item(make_item(KIND_TICK, $urandom, 1'b0, 1'($urandom_range(1)),
                                    12'd0, 12'hFFF, 11'd0, 1'($urandom_range(1))));

    settle();
    $display("run: %0d ticks, %0d remote writes, %0d idle-kind items, %0d settings",
             n_ticks, n_remote, n_nop, n_settings);
    $display("run: %0d status transactions checked, %0d with the error sum clipped",
             sb.checked, sb.clipped);
    if (sb.failures == 0 && sb.pending_status.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
